### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/sphh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral peak pair hasher package
// Sizes, constants, band edge table and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package sphh_pkg;

    localparam int unsigned NUM_BINS     = 1024;
    localparam int unsigned PEAK_COUNT   = 5;

    localparam int unsigned BIN_W        = $clog2(NUM_BINS);
    localparam int unsigned PK_IDX_W     = (PEAK_COUNT > 1) ? $clog2(PEAK_COUNT) : 1;
    localparam int unsigned POWER_W      = 32;
    localparam int unsigned RATE_W       = 18;
    localparam int unsigned HASH_W       = 32;
    localparam int unsigned OFFSET_W     = 31;
    localparam int unsigned FRAME_W      = 24;
    localparam int unsigned BAND_BIN_W   = 10;
    localparam int unsigned BAND_W       = 3;
    localparam int unsigned DELTA_W      = 12;
    localparam int unsigned LHS_W        = BIN_W + RATE_W;
    localparam int unsigned CMP_W        = 64;
    localparam int unsigned N_EDGES      = 6;

    localparam int unsigned HOP_MS_SCALE = 1024000;
    localparam int unsigned HOP_W        = $clog2(HOP_MS_SCALE + 1);
    localparam int unsigned DIVIDEND_W   = FRAME_W + HOP_W;
    localparam int unsigned DIV_CNT_W    = $clog2(DIVIDEND_W);

    localparam logic [BIN_W-1:0]    MIN_PEAK_BIN = BIN_W'(5);
    localparam logic [BIN_W-1:0]    LAST_BIN     = BIN_W'(NUM_BINS - 1);
    localparam logic [RATE_W-1:0]   RATE_RESET   = RATE_W'(44100);
    localparam logic [FRAME_W-1:0]  FRAME_MAX    = {FRAME_W{1'b1}};
    localparam logic [OFFSET_W-1:0] OFFSET_MAX   = {OFFSET_W{1'b1}};
    localparam logic [HOP_W-1:0]    HOP_SCALE    = HOP_W'(HOP_MS_SCALE);
    localparam logic [DELTA_W-1:0]  FRAME_DELTA  = DELTA_W'(1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(DIVIDEND_W - 1);

    // Band edge in Hz scaled by 2*NUM_BINS, so it compares directly with bin*rate.
    function automatic logic [CMP_W-1:0] band_limit(input int unsigned idx);
        logic [CMP_W-1:0] hz;
        case (idx)
            0:       hz = CMP_W'(200);
            1:       hz = CMP_W'(400);
            2:       hz = CMP_W'(800);
            3:       hz = CMP_W'(1600);
            4:       hz = CMP_W'(3200);
            default: hz = CMP_W'(6400);
        endcase
        return hz * CMP_W'(2 * NUM_BINS);
    endfunction

    typedef struct packed {
        logic accept_bin;
        logic start_div;
        logic div_step;
        logic emit_load;
        logic frame_wrap;
    } t_dp_cmd;

    typedef struct packed {
        logic last_bin;
        logic emit_now;
        logic div_last;
        logic out_free;
        logic last_peak;
    } t_dp_sts;

endpackage

### rtl/sphh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral peak pair hasher channels
// Valid/ready channels for spectrum bins in and pair hashes out.
// ----------------------------------------------------------------------------
interface sphh_bin_if import sphh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [POWER_W-1:0] bin_power;

    modport source (output valid, output bin_power, input ready);
    modport sink   (input valid, input bin_power, output ready);
endinterface

interface sphh_hash_if import sphh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [HASH_W-1:0]   pair_hash;
    logic [OFFSET_W-1:0] anchor_offset_ms;
    logic                run_last;

    modport source (output valid, output pair_hash, output anchor_offset_ms,
                    output run_last, input ready);
    modport sink   (input valid, input pair_hash, input anchor_offset_ms,
                    input run_last, output ready);
endinterface

### rtl/sphh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral peak pair hasher controller
// Sequences bin intake, the offset division, hash emission and frame rollover.
// ----------------------------------------------------------------------------
module sphh_ctrl import sphh_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_BINS  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_WRAP  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BINS;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_BINS: begin
                o_in_ready       = 1'b1;
                o_cmd.accept_bin = i_in_valid;
                if (i_in_valid && i_sts.last_bin) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.emit_now) begin
                    o_cmd.start_div = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_WRAP;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_sts.last_peak) begin
                        n_state = S_WRAP;
                    end
                end
            end
            S_WRAP: begin
                o_cmd.frame_wrap = 1'b1;
                n_state          = S_BINS;
            end
            default: begin
                n_state = S_BINS;
            end
        endcase
    end

endmodule

### rtl/sphh_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral peak pair hasher datapath
// Sorted peak list, band mapping, restoring divider and output word register.
// ----------------------------------------------------------------------------
module sphh_dp import sphh_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [RATE_W-1:0]   i_cfg_wdata,
    input  logic [POWER_W-1:0]  i_bin_power,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [HASH_W-1:0]   o_pair_hash,
    output logic [OFFSET_W-1:0] o_anchor_offset_ms,
    output logic                o_run_last
);

    logic [RATE_W-1:0]     r_rate;
    logic [BIN_W-1:0]      r_bin;
    logic [PEAK_COUNT-1:0] r_pk_valid;
    logic [POWER_W-1:0]    r_pk_power [PEAK_COUNT];
    logic [BIN_W-1:0]      r_pk_bin   [PEAK_COUNT];
    logic [BIN_W-1:0]      r_prev_bin;
    logic                  r_prev_valid;
    logic [FRAME_W-1:0]    r_frame;
    logic [BAND_BIN_W-1:0] r_anchor_band;
    logic [RATE_W-1:0]     r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic [PK_IDX_W-1:0]   r_k;
    logic                  r_out_valid;
    logic [HASH_W-1:0]     r_out_hash;
    logic [OFFSET_W-1:0]   r_out_ms;
    logic                  r_out_last;

    logic [PEAK_COUNT-1:0] n_pk_valid;
    logic [POWER_W-1:0]    n_pk_power [PEAK_COUNT];
    logic [BIN_W-1:0]      n_pk_bin   [PEAK_COUNT];

    logic [PEAK_COUNT-1:0] w_ge;
    logic [PEAK_COUNT:0]   w_ge_ext;
    logic                  w_insert;
    logic [PEAK_COUNT-1:0] w_tail;
    logic [BIN_W-1:0]      w_band_src;
    logic [LHS_W-1:0]      w_lhs;
    logic [BAND_W-1:0]     w_band;
    logic [BIN_W+6:0]      w_bin_x;
    logic [BAND_BIN_W-1:0] w_banded;
    logic [FRAME_W-1:0]    w_anchor_frame;
    logic [RATE_W:0]       w_trial;
    logic                  w_trial_ge;
    logic [RATE_W:0]       w_trial_diff;
    logic                  w_ms_sat;
    logic [OFFSET_W-1:0]   w_ms;

    // An entry at or above the new power keeps its place; the new bin goes
    // right after the last such entry, and everything below shifts down one.
    always_comb begin
        for (int i = 0; i < PEAK_COUNT; i++) begin
            w_ge[i] = r_pk_valid[i] && (r_pk_power[i] >= i_bin_power);
        end
        w_ge_ext = {w_ge, 1'b1};
        w_insert = i_cmd.accept_bin && (r_bin >= MIN_PEAK_BIN) && !w_ge[PEAK_COUNT-1];

        n_pk_valid = r_pk_valid;
        n_pk_power = r_pk_power;
        n_pk_bin   = r_pk_bin;
        if (w_insert) begin
            if (!w_ge[0]) begin
                n_pk_valid[0] = 1'b1;
                n_pk_power[0] = i_bin_power;
                n_pk_bin[0]   = r_bin;
            end
            for (int i = 1; i < PEAK_COUNT; i++) begin
                if (!w_ge[i]) begin
                    if (w_ge_ext[i]) begin
                        n_pk_valid[i] = 1'b1;
                        n_pk_power[i] = i_bin_power;
                        n_pk_bin[i]   = r_bin;
                    end else begin
                        n_pk_valid[i] = r_pk_valid[i-1];
                        n_pk_power[i] = r_pk_power[i-1];
                        n_pk_bin[i]   = r_pk_bin[i-1];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < PEAK_COUNT - 1; i++) begin
            w_tail[i] = !r_pk_valid[i+1];
        end
        w_tail[PEAK_COUNT-1] = 1'b1;
    end

    // Band mapping: the anchor during the division start, otherwise the
    // peak now being emitted.
    assign w_band_src = i_cmd.start_div ? r_prev_bin : r_pk_bin[r_k];
    assign w_lhs      = LHS_W'(w_band_src) * LHS_W'(r_rate);

    always_comb begin
        w_band = '0;
        for (int i = 0; i < N_EDGES; i++) begin
            if (CMP_W'(w_lhs) >= band_limit(i)) begin
                w_band = BAND_W'(i + 1);
            end
        end
    end

    assign w_bin_x  = {7'd0, w_band_src};
    assign w_banded = {w_band, w_bin_x[6:0]};

    assign w_anchor_frame = r_frame - 1'b1;

    // One quotient bit per cycle, most significant first.
    assign w_trial      = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_trial_ge   = w_trial >= {1'b0, r_rate};
    assign w_trial_diff = w_trial - {1'b0, r_rate};

    assign w_ms_sat = (r_rate == '0) || (|r_quo[DIVIDEND_W-1:OFFSET_W]);
    assign w_ms     = w_ms_sat ? OFFSET_MAX : r_quo[OFFSET_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate       <= RATE_RESET;
            r_bin        <= '0;
            r_pk_valid   <= '0;
            r_prev_bin   <= '0;
            r_prev_valid <= 1'b0;
            r_frame      <= '0;
            r_div_cnt    <= '0;
            r_k          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            if (i_cmd.accept_bin) begin
                r_bin      <= (r_bin == LAST_BIN) ? '0 : r_bin + 1'b1;
                r_pk_valid <= n_pk_valid;
            end
            if (i_cmd.start_div) begin
                r_div_cnt <= '0;
                r_k       <= '0;
            end
            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            if (i_cmd.emit_load) begin
                r_k         <= r_k + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.frame_wrap) begin
                if (r_pk_valid[0]) begin
                    r_prev_bin   <= r_pk_bin[0];
                    r_prev_valid <= 1'b1;
                end
                if (r_frame != FRAME_MAX) begin
                    r_frame <= r_frame + 1'b1;
                end
                r_pk_valid <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_bin) begin
            r_pk_power <= n_pk_power;
            r_pk_bin   <= n_pk_bin;
        end
        if (i_cmd.start_div) begin
            r_anchor_band <= w_banded;
            r_rem         <= '0;
            r_quo         <= {{HOP_W{1'b0}}, w_anchor_frame} * {{FRAME_W{1'b0}}, HOP_SCALE};
        end
        if (i_cmd.div_step) begin
            r_rem <= w_trial_ge ? w_trial_diff[RATE_W-1:0] : w_trial[RATE_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_trial_ge};
        end
        if (i_cmd.emit_load) begin
            r_out_hash <= {r_anchor_band, w_banded, FRAME_DELTA};
            r_out_ms   <= w_ms;
            r_out_last <= w_tail[r_k];
        end
    end

    always_comb begin
        o_sts.last_bin  = (r_bin == LAST_BIN);
        o_sts.emit_now  = r_prev_valid && r_pk_valid[0];
        o_sts.div_last  = (r_div_cnt == DIV_LAST);
        o_sts.out_free  = !r_out_valid || i_out_ready;
        o_sts.last_peak = w_tail[r_k];
    end

    assign o_out_valid        = r_out_valid;
    assign o_pair_hash        = r_out_hash;
    assign o_anchor_offset_ms = r_out_ms;
    assign o_run_last         = r_out_last;

endmodule

### rtl/spectral_peak_pair_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral peak pair hasher
// Keeps the strongest bins of each spectrum frame and pairs them with the
// previous frame's strongest bin into landmark hash words.
// ----------------------------------------------------------------------------
//  port        dir  word                                        handshake
//  i_bin       in   bin_power[31:0]                             valid/ready
//  o_hash      out  pair_hash[31:0], anchor_offset_ms[30:0],    valid/ready
//                   run_last
//  i_cfg_*     in   sample_rate[17:0]                           write enable
//
// A bin word is taken every cycle while a frame is streaming in.
// After the last bin of a frame the input stalls during the check and wrap
// states, plus the bit-serial offset divider and each emitted hash word when
// an anchor and a peak exist; a stalled output lengthens the emission phase.
// The output register lets the next frame start while the final hash waits.
// Reset is synchronous, active low, and restores sample_rate to 44100.
`include "assert_macros.svh"

module spectral_peak_pair_hasher import sphh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [RATE_W-1:0] i_cfg_wdata,
    sphh_bin_if.sink          i_bin,
    sphh_hash_if.source       o_hash
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    sphh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_bin.valid),
        .o_in_ready (i_bin.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sphh_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_bin_power        (i_bin.bin_power),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_out_ready        (o_hash.ready),
        .o_out_valid        (o_hash.valid),
        .o_pair_hash        (o_hash.pair_hash),
        .o_anchor_offset_ms (o_hash.anchor_offset_ms),
        .o_run_last         (o_hash.run_last)
    );

    // The last bin of a frame always stalls intake for the frame-end work.
    `ASSERT_NEXT(a_frame_end_stall, i_clk, i_rst_n, i_bin.valid && i_bin.ready && w_sts.last_bin, !i_bin.ready)
    // No bin is taken while the divider is running.
    `ASSERT_IMPLY(a_no_bin_in_div, i_clk, i_rst_n, w_cmd.div_step, !i_bin.ready)
    // A hash word is only loaded into a free output register.
    `ASSERT_IMPLY(a_emit_slot_free, i_clk, i_rst_n, w_cmd.emit_load, w_sts.out_free)

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral peak pair hasher testbench
// Streams whole spectrum frames into the hasher with random gaps on both
// channels and checks every hash word against a behavioral predictor that
// ranks the peaks of each frame and pairs them with the previous anchor.
// A short table of frames covers reset, ties, rate extremes and output
// back-pressure; random frames and random rate changes follow.
// ----------------------------------------------------------------------------
module tb_top import sphh_pkg::*; ();

    localparam int unsigned CLK_PERIOD     = 8;
    localparam int unsigned RESET_CYCLES   = 4;
    localparam int unsigned MAX_GAP        = 8;
    localparam int unsigned SETTLE_CYCLES  = 64;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_WORDS   = 48;
    localparam int unsigned N_ROWS         = 8;
    localparam int unsigned EDGE_HZ [6]    = '{200, 400, 800, 1600, 3200, 6400};

    typedef enum logic [2:0] {
        FILL_FLAT, FILL_RAMP, FILL_NOISE, FILL_SPIKES, FILL_ALTERNATE, FILL_LOW_BINS,
        FILL_TIES
    } t_fill;

    typedef struct packed {
        logic [HASH_W-1:0]   pair_hash;
        logic [OFFSET_W-1:0] ms_stamp;
        logic                run_last;
    } t_hash_word;

    typedef struct packed {
        logic                              set_rate;
        logic [RATE_W-1:0]                 rate;
        t_fill                             fill;
        logic [POWER_W-1:0]                level;
        logic                              typed;
        logic [2:0]                        n_typed;
        logic [0:PEAK_COUNT-1][HASH_W-1:0] hashes;
        logic [OFFSET_W-1:0]               ms_stamp;
        logic                              hold_out;
    } t_frame_row;

    // Frames with typed results: the first frame after reset gives nothing,
    // an all-equal frame ranks bins 5..9 by bin number, and a rising ramp at
    // a zero rate keeps every bin in band 0 with a saturated offset.
    t_frame_row directed_plan [N_ROWS] = '{
        '{set_rate: 1'b0, rate: '0, fill: FILL_FLAT, level: 32'h0000_0000,
          typed: 1'b1, n_typed: 3'd0, hashes: '0, ms_stamp: '0, hold_out: 1'b0},
        '{set_rate: 1'b0, rate: '0, fill: FILL_FLAT, level: 32'hFFFF_FFFF,
          typed: 1'b1, n_typed: 3'd5,
          hashes: {32'h0140_5001, 32'h0140_6001, 32'h0140_7001, 32'h0140_8001,
                   32'h0140_9001},
          ms_stamp: '0, hold_out: 1'b0},
        '{set_rate: 1'b1, rate: 18'd0, fill: FILL_RAMP, level: '0,
          typed: 1'b1, n_typed: 3'd5,
          hashes: {32'h0147_F001, 32'h0147_E001, 32'h0147_D001, 32'h0147_C001,
                   32'h0147_B001},
          ms_stamp: 31'h7FFF_FFFF, hold_out: 1'b0},
        '{set_rate: 1'b1, rate: 18'd192000, fill: FILL_NOISE, level: '0,
          typed: 1'b0, n_typed: '0, hashes: '0, ms_stamp: '0, hold_out: 1'b0},
        '{set_rate: 1'b1, rate: 18'd8000, fill: FILL_SPIKES, level: '0,
          typed: 1'b0, n_typed: '0, hashes: '0, ms_stamp: '0, hold_out: 1'b0},
        '{set_rate: 1'b1, rate: 18'h3FFFF, fill: FILL_ALTERNATE, level: '0,
          typed: 1'b0, n_typed: '0, hashes: '0, ms_stamp: '0, hold_out: 1'b0},
        '{set_rate: 1'b1, rate: 18'd1, fill: FILL_LOW_BINS, level: '0,
          typed: 1'b0, n_typed: '0, hashes: '0, ms_stamp: '0, hold_out: 1'b1},
        '{set_rate: 1'b0, rate: '0, fill: FILL_TIES, level: '0,
          typed: 1'b0, n_typed: '0, hashes: '0, ms_stamp: '0, hold_out: 1'b0}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_we;
    logic [RATE_W-1:0] cfg_wdata;

    sphh_bin_if  bin_if ();
    sphh_hash_if hash_if ();

    spectral_peak_pair_hasher DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_bin       (bin_if.sink),
        .o_hash      (hash_if.source)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Predictor state.
    logic [RATE_W-1:0]  model_rate;
    logic [BIN_W-1:0]   model_bin;
    logic [POWER_W-1:0] peak_power [PEAK_COUNT];
    logic [BIN_W-1:0]   peak_bin   [PEAK_COUNT];
    int unsigned        peak_total;
    logic [BIN_W-1:0]   anchor_bin;
    logic               anchor_ok;
    logic [FRAME_W-1:0] frame_no;

    t_hash_word  expected_hashes [$];
    t_hash_word  frame_hashes [$];
    int unsigned predicted_total;
    int unsigned checked_total;
    int unsigned error_count;
    int unsigned frames_sent;
    int unsigned bins_sent;
    int unsigned rate_writes;
    int unsigned quiet_cycles;
    bit          hold_out_req;
    bit          sink_burst;

    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("%0t ERROR %s: got %h, want %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic logic [BAND_BIN_W-1:0] band_word(input logic [BIN_W-1:0] bin);
        logic [63:0] prod;
        int unsigned band;
        prod = 64'(bin) * 64'(model_rate);
        band = 0;
        for (int i = 0; i < 6; i++) begin
            if (prod >= 64'(EDGE_HZ[i]) * 64'(2 * NUM_BINS))
                band = i + 1;
        end
        return BAND_BIN_W'(band * 128 + (bin & 127));
    endfunction

    task automatic clear_model();
        model_rate = RATE_RESET;
        model_bin  = '0;
        peak_total = 0;
        anchor_bin = '0;
        anchor_ok  = 1'b0;
        frame_no   = '0;
        for (int i = 0; i < PEAK_COUNT; i++) begin
            peak_power[i] = '0;
            peak_bin[i]   = '0;
        end
    endtask

    // Ranks one bin into the peak list; at the end of a frame it produces the
    // hash words that pair the previous anchor with each peak in rank order.
    task automatic rank_bin_and_hash(input logic [POWER_W-1:0] pw);
        int unsigned        pos;
        int unsigned        i;
        logic [FRAME_W-1:0] anchor_frame;
        logic [63:0]        ms;
        t_hash_word         w;
        if (model_bin >= MIN_PEAK_BIN) begin
            pos = peak_total;
            while (pos > 0 && peak_power[pos - 1] < pw)
                pos--;
            if (pos < PEAK_COUNT) begin
                i = (peak_total < PEAK_COUNT) ? peak_total : PEAK_COUNT - 1;
                while (i > pos) begin
                    peak_power[i] = peak_power[i - 1];
                    peak_bin[i]   = peak_bin[i - 1];
                    i--;
                end
                peak_power[pos] = pw;
                peak_bin[pos]   = model_bin;
                if (peak_total < PEAK_COUNT)
                    peak_total++;
            end
        end
        if (model_bin != LAST_BIN) begin
            model_bin++;
            return;
        end
        if (anchor_ok && peak_total > 0) begin
            anchor_frame = frame_no - 1'b1;
            if (model_rate == '0) begin
                ms = 64'(OFFSET_MAX);
            end else begin
                ms = (64'(anchor_frame) * 64'(HOP_MS_SCALE)) / 64'(model_rate);
                if (ms > 64'(OFFSET_MAX))
                    ms = 64'(OFFSET_MAX);
            end
            for (int k = 0; k < peak_total; k++) begin
                w.pair_hash = {band_word(anchor_bin), band_word(peak_bin[k]), FRAME_DELTA};
                w.ms_stamp  = ms[OFFSET_W-1:0];
                w.run_last  = (k == peak_total - 1);
                frame_hashes = {frame_hashes, w};
            end
        end
        if (peak_total > 0) begin
            anchor_bin = peak_bin[0];
            anchor_ok  = 1'b1;
        end
        if (frame_no != FRAME_MAX)
            frame_no++;
        model_bin  = '0;
        peak_total = 0;
        for (int k = 0; k < PEAK_COUNT; k++) begin
            peak_power[k] = '0;
            peak_bin[k]   = '0;
        end
    endtask

    function automatic logic [POWER_W-1:0] fill_word(input t_fill fill,
                                                     input logic [POWER_W-1:0] level,
                                                     input int unsigned bin);
        case (fill)
            FILL_FLAT:      return level;
            FILL_RAMP:      return POWER_W'(bin);
            FILL_NOISE:     return $urandom;
            FILL_SPIKES:    return ($urandom_range(0, 31) == 0) ? $urandom
                                                                : $urandom_range(0, 4095);
            FILL_ALTERNATE: return (bin % 2 == 1) ? {POWER_W{1'b1}} : {POWER_W{1'b0}};
            FILL_LOW_BINS:  return (bin < MIN_PEAK_BIN) ? {POWER_W{1'b1}}
                                                        : POWER_W'($urandom_range(0, 255));
            default:        return POWER_W'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic send_bin(input logic [POWER_W-1:0] pw, input int unsigned gap);
        @(negedge i_clk);
        if (gap > 0) begin
            bin_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        bin_if.valid     <= 1'b1;
        bin_if.bin_power <= pw;
        do @(posedge i_clk); while (!bin_if.ready);
    endtask

    task automatic drive_frame(input t_frame_row row);
        logic [POWER_W-1:0] pw;
        bit                 burst;
        t_hash_word         w;
        burst = ($urandom_range(0, 2) == 0);
        for (int b = 0; b < NUM_BINS; b++) begin
            pw = fill_word(row.fill, row.level, b);
            send_bin(pw, burst ? 0 : $urandom_range(0, MAX_GAP));
            bins_sent++;
            if (row.hold_out && b == NUM_BINS - 1)
                hold_out_req = 1'b1;
            rank_bin_and_hash(pw);
            if (row.typed && b == NUM_BINS - 1) begin
                for (int k = 0; k < row.n_typed; k++) begin
                    w.pair_hash = row.hashes[k];
                    w.ms_stamp  = row.ms_stamp;
                    w.run_last  = (k == row.n_typed - 1);
                    expected_hashes = {expected_hashes, w};
                    predicted_total++;
                end
                frame_hashes.delete();
            end else begin
                while (frame_hashes.size() != 0) begin
                    w = frame_hashes.pop_front();
                    expected_hashes = {expected_hashes, w};
                    predicted_total++;
                end
            end
        end
        frames_sent++;
    endtask

    // The rate is only changed once the block has drained and gone quiet.
    task automatic write_rate(input logic [RATE_W-1:0] rate);
        @(negedge i_clk);
        bin_if.valid <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= rate;
        @(negedge i_clk);
        cfg_we     <= 1'b0;
        model_rate = rate;
        rate_writes++;
    endtask

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 7))
            0:       return RATE_W'(8000);
            1:       return RATE_W'(192000);
            2:       return '0;
            3:       return '1;
            4:       return RATE_W'($urandom_range(1, 7999));
            default: return RATE_W'($urandom_range(8000, 192000));
        endcase
    endfunction

    function automatic t_fill pick_fill();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return FILL_NOISE;
            4, 5, 6:    return FILL_SPIKES;
            7:          return FILL_TIES;
            8:          return FILL_FLAT;
            default:    return ($urandom_range(0, 1) == 0) ? FILL_ALTERNATE : FILL_LOW_BINS;
        endcase
    endfunction

    task automatic check_hash_word(input t_hash_word got);
        t_hash_word want;
        if (expected_hashes.size() == 0) begin
            report_error("hash word with none pending", got.pair_hash, '0);
            return;
        end
        want = expected_hashes.pop_front();
        checked_total++;
        if (got.pair_hash !== want.pair_hash)
            report_error("pair_hash", got.pair_hash, want.pair_hash);
        if (got.ms_stamp !== want.ms_stamp)
            report_error("anchor_offset_ms", 32'(got.ms_stamp), 32'(want.ms_stamp));
        if (got.run_last !== want.run_last)
            report_error("run_last", 32'(got.run_last), 32'(want.run_last));
    endtask

    // Hash sink: a random stall per word, bursts with no stall, and long
    // hold-offs that back the block up into its input.
    initial begin : hash_sink
        int unsigned stall;
        hash_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0)
                sink_burst = ~sink_burst;
            if (hold_out_req) begin
                stall        = LONG_HOLD;
                hold_out_req = 1'b0;
            end else begin
                stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            @(negedge i_clk);
            if (stall > 0) begin
                hash_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            hash_if.ready <= 1'b1;
            do @(posedge i_clk); while (!hash_if.valid);
            check_hash_word({hash_if.pair_hash, hash_if.anchor_offset_ms, hash_if.run_last});
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (bin_if.valid && bin_if.ready) || (hash_if.valid && hash_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("spectral_peak_pair_hasher: mismatch");
            $finish;
        end
    end

    initial begin : bin_source
        t_frame_row  row;
        int unsigned random_start;
        int unsigned random_frames;
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        bin_if.valid     = 1'b0;
        bin_if.bin_power = '0;
        predicted_total  = 0;
        checked_total    = 0;
        error_count      = 0;
        frames_sent      = 0;
        bins_sent        = 0;
        rate_writes      = 0;
        quiet_cycles     = 0;
        hold_out_req     = 1'b0;
        sink_burst       = 1'b0;
        random_frames    = 0;
        clear_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            if (directed_plan[r].set_rate)
                write_rate(directed_plan[r].rate);
            drive_frame(directed_plan[r]);
        end

        random_start = predicted_total;
        while (predicted_total - random_start < RANDOM_WORDS) begin
            if (random_frames > 0 && $urandom_range(0, 2) == 0)
                write_rate(pick_rate());
            row          = '0;
            row.fill     = pick_fill();
            row.level    = $urandom;
            row.hold_out = ($urandom_range(0, 5) == 0);
            drive_frame(row);
            random_frames++;
        end

        @(negedge i_clk);
        bin_if.valid <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_hashes.size() != 0)
            report_error("hash words never produced", expected_hashes.size(), '0);

        $display("Streamed %0d frames (%0d bins, %0d random) over %0d rate settings.",
                 frames_sent, bins_sent, random_frames, rate_writes + 1);
        $display("Checked %0d hash words field by field; %0d errors.",
                 checked_total, error_count);
        if (error_count == 0)
            $display("spectral_peak_pair_hasher: match");
        else
            $display("spectral_peak_pair_hasher: mismatch");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/sphh_pkg.sv
rtl/sphh_if.sv
rtl/sphh_ctrl.sv
rtl/sphh_dp.sv
rtl/spectral_peak_pair_hasher.sv
sim/tb_top.sv
